[sv/vector_path_command_resolver_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the vector path command resolver
// Wraps concurrent assertions so they can be compiled out as a group.
// ----------------------------------------------------------------------------
`ifndef VECTOR_PATH_COMMAND_RESOLVER_CORE_ASSERT_SVH
`define VECTOR_PATH_COMMAND_RESOLVER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// antecedent true implies consequent in the same cycle
`define VPCR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vpcr same-cycle check failed");

// antecedent true implies consequent in the next cycle
`define VPCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vpcr next-cycle check failed");

`else

`define VPCR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define VPCR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/vpcr_pkg.sv]
// ----------------------------------------------------------------------------
// vpcr_pkg
// Command codes, pen state and result types, and saturating Q16.16 helpers.
// ----------------------------------------------------------------------------
package vpcr_pkg;

  // input command codes
  typedef enum logic [3:0] {
    MODE_MOVE    = 4'd0,
    MODE_LINE    = 4'd1,
    MODE_HORIZ   = 4'd2,
    MODE_VERT    = 4'd3,
    MODE_CUBIC   = 4'd4,
    MODE_SCUBIC  = 4'd5,
    MODE_QUAD    = 4'd6,
    MODE_SQUAD   = 4'd7,
    MODE_ARC     = 4'd8,
    MODE_CLOSE   = 4'd9
  } mode_t;

  // output command kinds
  typedef enum logic [2:0] {
    KIND_MOVE  = 3'd0,
    KIND_LINE  = 3'd1,
    KIND_QUAD  = 3'd2,
    KIND_CUBIC = 3'd3,
    KIND_ARC   = 3'd4,
    KIND_CLOSE = 3'd5
  } kind_t;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // kept pen state
  typedef struct packed {
    logic signed [31:0] pen_x;
    logic signed [31:0] pen_y;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] ctrl_x;
    logic signed [31:0] ctrl_y;
    logic               ctrl_valid;
    logic               subpath_open;
  } pen_state_t;

  // one resolved absolute command
  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] o0;
    logic signed [31:0] o1;
    logic signed [31:0] o2;
    logic signed [31:0] o3;
    logic signed [31:0] o4;
    logic signed [31:0] o5;
    logic               large_arc;
    logic               sweep;
  } cmd_res_t;

  // a + b clamped to the 32-bit signed range
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? Q_MIN : Q_MAX;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  // operand made absolute when relative
  function automatic logic signed [31:0] offs(input logic signed [31:0] v,
                                              input logic signed [31:0] base,
                                              input logic               rel);
    offs = rel ? sat_add(v, base) : v;
  endfunction

  // 2*p - c clamped to the 32-bit signed range
  function automatic logic signed [31:0] reflect(input logic signed [31:0] p,
                                                 input logic signed [31:0] c);
    logic signed [33:0] d;
    d = {p[31], p, 1'b0} - {{2{c[31]}}, c};
    if ((d[33] != d[32]) || (d[32] != d[31])) begin
      reflect = d[33] ? Q_MIN : Q_MAX;
    end else begin
      reflect = d[31:0];
    end
  endfunction

endpackage

[sv/vpcr_resolve.sv]
// ----------------------------------------------------------------------------
// vpcr_resolve
// Combinational resolve of one path command against the pen state: gives the
// absolute command and the next pen state.
// ----------------------------------------------------------------------------
module vpcr_resolve
  import vpcr_pkg::*;
(
  input  logic [3:0]         mode,
  input  logic               relative,
  input  logic signed [31:0] arg0,
  input  logic signed [31:0] arg1,
  input  logic signed [31:0] arg2,
  input  logic signed [31:0] arg3,
  input  logic signed [31:0] arg4,
  input  logic signed [31:0] arg5,
  input  logic               large_arc_in,
  input  logic               sweep_in,
  input  pen_state_t         st,
  output cmd_res_t           res,
  output logic               has_result,
  output pen_state_t         st_nxt
);

  logic signed [31:0] ax0, ay1, ax2, ay3, ax4, ay5;
  logic signed [31:0] ax3, ay4, ay0;
  logic signed [31:0] rx1, ry1;

  // absolute operands for every slot that may be a coordinate
  assign ax0 = offs(arg0, st.pen_x, relative);
  assign ay1 = offs(arg1, st.pen_y, relative);
  assign ax2 = offs(arg2, st.pen_x, relative);
  assign ay3 = offs(arg3, st.pen_y, relative);
  assign ax4 = offs(arg4, st.pen_x, relative);
  assign ay5 = offs(arg5, st.pen_y, relative);
  assign ax3 = offs(arg3, st.pen_x, relative);   // arc end x
  assign ay4 = offs(arg4, st.pen_y, relative);   // arc end y
  assign ay0 = offs(arg0, st.pen_y, relative);   // vertical target

  // first control point of the smooth forms
  assign rx1 = st.ctrl_valid ? reflect(st.pen_x, st.ctrl_x) : st.pen_x;
  assign ry1 = st.ctrl_valid ? reflect(st.pen_y, st.ctrl_y) : st.pen_y;

  always_comb begin
    res        = '0;
    res.kind   = KIND_CLOSE;
    st_nxt     = st;
    has_result = 1'b1;
    unique case (mode_t'(mode))
      MODE_MOVE: begin
        res.kind       = KIND_MOVE;
        res.o0         = ax0;
        res.o1         = ay1;
        st_nxt.pen_x   = ax0;
        st_nxt.pen_y   = ay1;
        st_nxt.start_x = ax0;
        st_nxt.start_y = ay1;
        st_nxt.ctrl_valid   = 1'b0;
        st_nxt.subpath_open = 1'b1;
      end
      MODE_LINE: begin
        res.kind   = KIND_LINE;
        res.o0     = ax0;
        res.o1     = ay1;
        st_nxt.pen_x      = ax0;
        st_nxt.pen_y      = ay1;
        st_nxt.ctrl_valid = 1'b0;
      end
      MODE_HORIZ: begin
        res.kind   = KIND_LINE;
        res.o0     = ax0;
        res.o1     = st.pen_y;
        st_nxt.pen_x      = ax0;
        st_nxt.ctrl_valid = 1'b0;
      end
      MODE_VERT: begin
        res.kind   = KIND_LINE;
        res.o0     = st.pen_x;
        res.o1     = ay0;
        st_nxt.pen_y      = ay0;
        st_nxt.ctrl_valid = 1'b0;
      end
      MODE_CUBIC: begin
        res.kind = KIND_CUBIC;
        res.o0 = ax0; res.o1 = ay1;
        res.o2 = ax2; res.o3 = ay3;
        res.o4 = ax4; res.o5 = ay5;
        st_nxt.ctrl_x     = ax2;
        st_nxt.ctrl_y     = ay3;
        st_nxt.ctrl_valid = 1'b1;
        st_nxt.pen_x      = ax4;
        st_nxt.pen_y      = ay5;
      end
      MODE_SCUBIC: begin
        res.kind = KIND_CUBIC;
        res.o0 = rx1; res.o1 = ry1;
        res.o2 = ax0; res.o3 = ay1;
        res.o4 = ax2; res.o5 = ay3;
        st_nxt.ctrl_x     = ax0;
        st_nxt.ctrl_y     = ay1;
        st_nxt.ctrl_valid = 1'b1;
        st_nxt.pen_x      = ax2;
        st_nxt.pen_y      = ay3;
      end
      MODE_QUAD: begin
        res.kind = KIND_QUAD;
        res.o0 = ax0; res.o1 = ay1;
        res.o2 = ax2; res.o3 = ay3;
        st_nxt.ctrl_x     = ax0;
        st_nxt.ctrl_y     = ay1;
        st_nxt.ctrl_valid = 1'b1;
        st_nxt.pen_x      = ax2;
        st_nxt.pen_y      = ay3;
      end
      MODE_SQUAD: begin
        res.kind = KIND_QUAD;
        res.o0 = rx1; res.o1 = ry1;
        res.o2 = ax0; res.o3 = ay1;
        st_nxt.ctrl_x     = rx1;
        st_nxt.ctrl_y     = ry1;
        st_nxt.ctrl_valid = 1'b1;
        st_nxt.pen_x      = ax0;
        st_nxt.pen_y      = ay1;
      end
      MODE_ARC: begin
        st_nxt.pen_x      = ax3;
        st_nxt.pen_y      = ay4;
        st_nxt.ctrl_valid = 1'b0;
        // zero radius degrades to a straight line
        if ((arg0 == '0) || (arg1 == '0)) begin
          res.kind = KIND_LINE;
          res.o0   = ax3;
          res.o1   = ay4;
        end else begin
          res.kind      = KIND_ARC;
          res.o0        = arg0;
          res.o1        = arg1;
          res.o2        = ax3;
          res.o3        = ay4;
          res.o4        = arg2;
          res.large_arc = large_arc_in;
          res.sweep     = sweep_in;
        end
      end
      MODE_CLOSE: begin
        res.kind = KIND_CLOSE;
        if (st.subpath_open) begin
          st_nxt.pen_x        = st.start_x;
          st_nxt.pen_y        = st.start_y;
          st_nxt.subpath_open = 1'b0;
        end
        st_nxt.ctrl_valid = 1'b0;
      end
      default: begin
        // unused codes: dropped, state untouched
        has_result = 1'b0;
      end
    endcase
  end

endmodule

[sv/vector_path_command_resolver_core.sv]
// ----------------------------------------------------------------------------
// vector_path_command_resolver_core
// Resolves tokenized path commands into absolute moveto, lineto, quadto,
// cubicto, arcto and closepath commands against a kept pen state.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  in      | in_valid / in_ready  | mode, relative, arg0..arg5, arc flags
//  out     | out_valid / out_ready| kind, out0..out5, arc flags
//
//  One item per cycle while the output is not stalled; a result is registered and
//  appears in the cycle after its item is taken. The pen state updates at the
//  accepting edge, so the next item sees it. in_ready is high while the result
//  register is empty or being drained. Unused command codes are taken and
//  dropped without a result. Synchronous active-low reset clears the pen state and the output valid.
// ----------------------------------------------------------------------------
`include "vector_path_command_resolver_core_assert.svh"

module vector_path_command_resolver_core
  import vpcr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_mode,
  input  logic               in_relative,
  input  logic signed [31:0] in_arg0,
  input  logic signed [31:0] in_arg1,
  input  logic signed [31:0] in_arg2,
  input  logic signed [31:0] in_arg3,
  input  logic signed [31:0] in_arg4,
  input  logic signed [31:0] in_arg5,
  input  logic               in_large_arc_in,
  input  logic               in_sweep_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_kind,
  output logic signed [31:0] out_out0,
  output logic signed [31:0] out_out1,
  output logic signed [31:0] out_out2,
  output logic signed [31:0] out_out3,
  output logic signed [31:0] out_out4,
  output logic signed [31:0] out_out5,
  output logic               out_large_arc_out,
  output logic               out_sweep_out
);

  pen_state_t st_r, st_nxt;
  cmd_res_t   res_r, res_nxt;
  logic       out_valid_r;
  logic       has_result;
  logic       in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  vpcr_resolve u_resolve (
    .mode         (in_mode),
    .relative     (in_relative),
    .arg0         (in_arg0),
    .arg1         (in_arg1),
    .arg2         (in_arg2),
    .arg3         (in_arg3),
    .arg4         (in_arg4),
    .arg5         (in_arg5),
    .large_arc_in (in_large_arc_in),
    .sweep_in     (in_sweep_in),
    .st           (st_r),
    .res          (res_nxt),
    .has_result   (has_result),
    .st_nxt       (st_nxt)
  );

  // pen state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r        <= st_nxt;
        out_valid_r <= has_result;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire && has_result) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = res_r.kind;
  assign out_out0          = res_r.o0;
  assign out_out1          = res_r.o1;
  assign out_out2          = res_r.o2;
  assign out_out3          = res_r.o3;
  assign out_out4          = res_r.o4;
  assign out_out5          = res_r.o5;
  assign out_large_arc_out = res_r.large_arc;
  assign out_sweep_out     = res_r.sweep;

  // checks
  `VPCR_ASSERT_NEXT(a_unused_keeps_state, clk, rst_n,
                    in_fire && (in_mode > MODE_CLOSE), $stable(st_r))
  `VPCR_ASSERT_SAME(a_flags_arc_only, clk, rst_n,
                    out_valid_r && (res_r.kind != KIND_ARC),
                    !res_r.large_arc && !res_r.sweep)
  `VPCR_ASSERT_SAME(a_close_zero, clk, rst_n,
                    out_valid_r && (res_r.kind == KIND_CLOSE),
                    (res_r.o0 == '0) && (res_r.o1 == '0))
  `VPCR_ASSERT_NEXT(a_curve_sets_ctrl, clk, rst_n,
                    in_fire && has_result &&
                    ((res_nxt.kind == KIND_CUBIC) || (res_nxt.kind == KIND_QUAD)),
                    st_r.ctrl_valid)

endmodule

[tb/tb_vector_path_command_resolver_core.sv]
// ----------------------------------------------------------------------------
// tb_vector_path_command_resolver_core
// Drives tokenized path commands through the resolver with random gaps and
// output stalls, tracks the pen in a local model of the resolver, and checks
// every resolved absolute command field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_vector_path_command_resolver_core;
  import vpcr_pkg::*;

  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic [3:0] MODE_UNUSED_LO = MODE_CLOSE + 4'd1;
  localparam logic [3:0] MODE_UNUSED_HI = 4'hF;

  // one tokenized command as seen on the input ports
  typedef struct packed {
    logic [3:0]         mode;
    logic               rel;
    logic signed [31:0] a0, a1, a2, a3, a4, a5;
    logic               large_arc;
    logic               sweep;
  } path_cmd_t;

  // pen tracking and the queue of resolved commands still to arrive
  class path_resolve_tracker;
    pen_state_t  pen = '0;
    cmd_res_t    pending_q[$];
    int unsigned mismatches = 0;
    int unsigned taken = 0;
    int unsigned dropped = 0;
    int unsigned checked = 0;

    function logic signed [31:0] clamp_q(input longint v);
      if (v > longint'(Q_MAX)) return Q_MAX;
      if (v < longint'(Q_MIN)) return Q_MIN;
      return v[31:0];
    endfunction

    function logic signed [31:0] abs_coord(input logic signed [31:0] v, base,
                                           input logic rel);
      return rel ? clamp_q(longint'(v) + longint'(base)) : v;
    endfunction

    // first control point of a smooth curve
    function logic signed [31:0] mirror_pt(input logic signed [31:0] p, c);
      return pen.ctrl_valid ? clamp_q(2 * longint'(p) - longint'(c)) : p;
    endfunction

    function void note_command(input path_cmd_t c);
      cmd_res_t r;
      logic signed [31:0] x, y;
      r = '0;
      taken++;
      case (c.mode)
        MODE_MOVE, MODE_LINE: begin
          x = abs_coord(c.a0, pen.pen_x, c.rel);
          y = abs_coord(c.a1, pen.pen_y, c.rel);
          pen.pen_x = x;
          pen.pen_y = y;
          pen.ctrl_valid = 1'b0;
          if (c.mode == MODE_MOVE) begin
            pen.start_x = x;
            pen.start_y = y;
            pen.subpath_open = 1'b1;
            r.kind = KIND_MOVE;
          end else begin
            r.kind = KIND_LINE;
          end
          r.o0 = x;
          r.o1 = y;
        end
        MODE_HORIZ, MODE_VERT: begin
          if (c.mode == MODE_HORIZ) pen.pen_x = abs_coord(c.a0, pen.pen_x, c.rel);
          else pen.pen_y = abs_coord(c.a0, pen.pen_y, c.rel);
          pen.ctrl_valid = 1'b0;
          r.kind = KIND_LINE;
          r.o0 = pen.pen_x;
          r.o1 = pen.pen_y;
        end
        MODE_CUBIC, MODE_SCUBIC: begin
          if (c.mode == MODE_CUBIC) begin
            r.o0 = abs_coord(c.a0, pen.pen_x, c.rel);
            r.o1 = abs_coord(c.a1, pen.pen_y, c.rel);
            r.o2 = abs_coord(c.a2, pen.pen_x, c.rel);
            r.o3 = abs_coord(c.a3, pen.pen_y, c.rel);
            r.o4 = abs_coord(c.a4, pen.pen_x, c.rel);
            r.o5 = abs_coord(c.a5, pen.pen_y, c.rel);
          end else begin
            r.o0 = mirror_pt(pen.pen_x, pen.ctrl_x);
            r.o1 = mirror_pt(pen.pen_y, pen.ctrl_y);
            r.o2 = abs_coord(c.a0, pen.pen_x, c.rel);
            r.o3 = abs_coord(c.a1, pen.pen_y, c.rel);
            r.o4 = abs_coord(c.a2, pen.pen_x, c.rel);
            r.o5 = abs_coord(c.a3, pen.pen_y, c.rel);
          end
          // cubics keep the second control point
          pen.ctrl_x = r.o2;
          pen.ctrl_y = r.o3;
          pen.ctrl_valid = 1'b1;
          pen.pen_x = r.o4;
          pen.pen_y = r.o5;
          r.kind = KIND_CUBIC;
        end
        MODE_QUAD, MODE_SQUAD: begin
          if (c.mode == MODE_QUAD) begin
            r.o0 = abs_coord(c.a0, pen.pen_x, c.rel);
            r.o1 = abs_coord(c.a1, pen.pen_y, c.rel);
            r.o2 = abs_coord(c.a2, pen.pen_x, c.rel);
            r.o3 = abs_coord(c.a3, pen.pen_y, c.rel);
          end else begin
            r.o0 = mirror_pt(pen.pen_x, pen.ctrl_x);
            r.o1 = mirror_pt(pen.pen_y, pen.ctrl_y);
            r.o2 = abs_coord(c.a0, pen.pen_x, c.rel);
            r.o3 = abs_coord(c.a1, pen.pen_y, c.rel);
          end
          // quads keep their only control point
          pen.ctrl_x = r.o0;
          pen.ctrl_y = r.o1;
          pen.ctrl_valid = 1'b1;
          pen.pen_x = r.o2;
          pen.pen_y = r.o3;
          r.kind = KIND_QUAD;
        end
        MODE_ARC: begin
          x = abs_coord(c.a3, pen.pen_x, c.rel);
          y = abs_coord(c.a4, pen.pen_y, c.rel);
          pen.pen_x = x;
          pen.pen_y = y;
          pen.ctrl_valid = 1'b0;
          if (c.a0 == 0 || c.a1 == 0) begin
            // degenerate radius: straight line, flags dropped
            r.kind = KIND_LINE;
            r.o0 = x;
            r.o1 = y;
          end else begin
            r.kind = KIND_ARC;
            r.o0 = c.a0;
            r.o1 = c.a1;
            r.o2 = x;
            r.o3 = y;
            r.o4 = c.a2;
            r.large_arc = c.large_arc;
            r.sweep = c.sweep;
          end
        end
        MODE_CLOSE: begin
          if (pen.subpath_open) begin
            pen.pen_x = pen.start_x;
            pen.pen_y = pen.start_y;
            pen.subpath_open = 1'b0;
          end
          pen.ctrl_valid = 1'b0;
          r.kind = KIND_CLOSE;
        end
        default: begin
          // unused code: swallowed, no result
          dropped++;
          return;
        end
      endcase
      pending_q.push_back(r);
    endfunction

    function void cmp_field(input string name, input logic [31:0] want_v, got_v);
      if (got_v !== want_v) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: %s want %h got %h", checked, name, want_v, got_v);
      end
    endfunction

    function void check_result(input cmd_res_t got);
      cmd_res_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing pending: kind %0d out0 %h", got.kind, got.o0);
        return;
      end
      want = pending_q.pop_front();
      checked++;
      cmp_field("kind", 32'(want.kind), 32'(got.kind));
      cmp_field("out0", want.o0, got.o0);
      cmp_field("out1", want.o1, got.o1);
      cmp_field("out2", want.o2, got.o2);
      cmp_field("out3", want.o3, got.o3);
      cmp_field("out4", want.o4, got.o4);
      cmp_field("out5", want.o5, got.o5);
      cmp_field("large_arc", 32'(want.large_arc), 32'(got.large_arc));
      cmp_field("sweep", 32'(want.sweep), 32'(got.sweep));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         in_mode = MODE_MOVE;
  logic               in_relative = 1'b0;
  logic signed [31:0] in_arg0 = '0;
  logic signed [31:0] in_arg1 = '0;
  logic signed [31:0] in_arg2 = '0;
  logic signed [31:0] in_arg3 = '0;
  logic signed [31:0] in_arg4 = '0;
  logic signed [31:0] in_arg5 = '0;
  logic               in_large_arc_in = 1'b0;
  logic               in_sweep_in = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_kind;
  logic signed [31:0] out_out0, out_out1, out_out2, out_out3, out_out4, out_out5;
  logic               out_large_arc_out;
  logic               out_sweep_out;

  // idle chance in percent for each side; zero turns idling off
  int unsigned gap_odds = 20;
  int unsigned stall_odds = 20;

  path_resolve_tracker tracker = new;

  vector_path_command_resolver_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_relative       (in_relative),
    .in_arg0           (in_arg0),
    .in_arg1           (in_arg1),
    .in_arg2           (in_arg2),
    .in_arg3           (in_arg3),
    .in_arg4           (in_arg4),
    .in_arg5           (in_arg5),
    .in_large_arc_in   (in_large_arc_in),
    .in_sweep_in       (in_sweep_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_out0          (out_out0),
    .out_out1          (out_out1),
    .out_out2          (out_out2),
    .out_out3          (out_out3),
    .out_out4          (out_out4),
    .out_out5          (out_out5),
    .out_large_arc_out (out_large_arc_out),
    .out_sweep_out     (out_sweep_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // handshake monitor: new item noted before the result check of the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        tracker.note_command({in_mode, in_relative, in_arg0, in_arg1, in_arg2, in_arg3,
                              in_arg4, in_arg5, in_large_arc_in, in_sweep_in});
      if (out_valid && out_ready)
        tracker.check_result({out_kind, out_out0, out_out1, out_out2, out_out3, out_out4,
                              out_out5, out_large_arc_out, out_sweep_out});
    end
  end

  // result side: random stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (stall_odds != 0 && $urandom_range(0, 99) < stall_odds) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // coordinates biased toward the range ends and small values
  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 9))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
      4, 5, 6: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic path_cmd_t with_args(input logic [3:0] m, input logic r,
                                          input logic signed [31:0] a0, a1, a2,
                                          a3, a4, a5);
    path_cmd_t c;
    c.mode = m;
    c.rel = r;
    c.a0 = a0;
    c.a1 = a1;
    c.a2 = a2;
    c.a3 = a3;
    c.a4 = a4;
    c.a5 = a5;
    c.large_arc = 1'($urandom_range(0, 1));
    c.sweep = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic path_cmd_t random_cmd(input logic [3:0] m);
    path_cmd_t c;
    c = with_args(m, 1'($urandom_range(0, 1)), rand_q(), rand_q(), rand_q(), rand_q(),
                  rand_q(), rand_q());
    // extra weight on the zero-radius arc
    if (m == MODE_ARC && $urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 1)) c.a0 = '0;
      else c.a1 = '0;
    end
    return c;
  endfunction

  function automatic logic [3:0] pick_segment();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
    if (r < 7) return MODE_CLOSE;
    return 4'($urandom_range(MODE_LINE, MODE_ARC));
  endfunction

  // called at a rising edge; returns at the edge that takes the item
  task automatic send_cmd(input path_cmd_t c);
    if (gap_odds != 0 && $urandom_range(0, 99) < gap_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= c.mode;
    in_relative     <= c.rel;
    in_arg0         <= c.a0;
    in_arg1         <= c.a1;
    in_arg2         <= c.a2;
    in_arg3         <= c.a3;
    in_arg4         <= c.a4;
    in_arg5         <= c.a5;
    in_large_arc_in <= c.large_arc;
    in_sweep_in     <= c.sweep;
    @(negedge clk);
    while (in_ready !== 1'b1) @(negedge clk);
    @(posedge clk);
  endtask

  // hold the input off until every pending result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (tracker.pending_q.size() != 0);
    @(posedge clk);
  endtask

  // subpaths: mostly move, segments, close; some lack the move or the close
  task automatic run_paths(input int unsigned n_items);
    int unsigned sent;
    path_cmd_t c;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 7) != 0) begin
        send_cmd(random_cmd(MODE_MOVE));
        sent++;
      end
      repeat ($urandom_range(1, 8)) begin
        c = random_cmd(pick_segment());
        send_cmd(c);
        if (c.mode <= MODE_CLOSE) sent++;
      end
      if ($urandom_range(0, 2) != 0) begin
        send_cmd(random_cmd(MODE_CLOSE));
        sent++;
      end
      if ($urandom_range(0, 39) == 0) drain_results();
    end
  endtask

  initial begin
    path_cmd_t c;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // close right after reset, nothing open
    send_cmd(with_args(MODE_CLOSE, 1'b0, rand_q(), rand_q(), rand_q(), rand_q(),
                       rand_q(), rand_q()));
    // smooth forms with no kept control point
    send_cmd(with_args(MODE_SCUBIC, 1'b0, ONE, 2 * ONE, 3 * ONE, -ONE, rand_q(), rand_q()));
    send_cmd(with_args(MODE_SQUAD, 1'b1, 32'sd1, -32'sd1, rand_q(), rand_q(), rand_q(),
                       rand_q()));
    // saturating relative adds at both ends
    send_cmd(with_args(MODE_MOVE, 1'b0, Q_MAX, Q_MAX, rand_q(), rand_q(), rand_q(), rand_q()));
    send_cmd(with_args(MODE_LINE, 1'b1, 32'sd1, 32'sd1, rand_q(), rand_q(), rand_q(), rand_q()));
    send_cmd(with_args(MODE_LINE, 1'b1, Q_MIN, Q_MIN, rand_q(), rand_q(), rand_q(), rand_q()));
    send_cmd(with_args(MODE_MOVE, 1'b0, Q_MIN, Q_MIN, rand_q(), rand_q(), rand_q(), rand_q()));
    send_cmd(with_args(MODE_LINE, 1'b1, -32'sd1, -32'sd1, rand_q(), rand_q(), rand_q(),
                       rand_q()));
    send_cmd(with_args(MODE_HORIZ, 1'b0, Q_MAX, rand_q(), rand_q(), rand_q(), rand_q(),
                       rand_q()));
    send_cmd(with_args(MODE_VERT, 1'b1, Q_MIN, rand_q(), rand_q(), rand_q(), rand_q(),
                       rand_q()));
    // reflections that overflow in both directions
    send_cmd(with_args(MODE_CUBIC, 1'b0, '0, '0, Q_MIN, Q_MIN, Q_MAX, Q_MAX));
    send_cmd(with_args(MODE_SCUBIC, 1'b0, Q_MAX, Q_MAX, Q_MIN, Q_MIN, rand_q(), rand_q()));
    send_cmd(with_args(MODE_SQUAD, 1'b0, '0, '0, rand_q(), rand_q(), rand_q(), rand_q()));
    send_cmd(with_args(MODE_SQUAD, 1'b1, ONE / 2, '0, rand_q(), rand_q(), rand_q(), rand_q()));
    send_cmd(with_args(MODE_QUAD, 1'b1, ONE, 2 * ONE, -ONE, 3 * ONE, rand_q(), rand_q()));
    send_cmd(with_args(MODE_SQUAD, 1'b1, 5 * ONE, -ONE, rand_q(), rand_q(), rand_q(),
                       rand_q()));
    // arcs: regular, each radius zero, negative radii
    c = with_args(MODE_ARC, 1'b1, 5 * ONE, 3 * ONE, 45 * ONE, ONE, ONE, rand_q());
    c.large_arc = 1'b1;
    c.sweep = 1'b1;
    send_cmd(c);
    c = with_args(MODE_ARC, 1'b0, '0, 5 * ONE, 30 * ONE, 2 * ONE, 4 * ONE, rand_q());
    c.large_arc = 1'b1;
    c.sweep = 1'b1;
    send_cmd(c);
    c = with_args(MODE_ARC, 1'b0, 5 * ONE, '0, 30 * ONE, -2 * ONE, 4 * ONE, rand_q());
    c.large_arc = 1'b1;
    c.sweep = 1'b1;
    send_cmd(c);
    c = with_args(MODE_ARC, 1'b0, -2 * ONE, -32'sd1, -90 * ONE, 7 * ONE, -7 * ONE, rand_q());
    c.large_arc = 1'b0;
    c.sweep = 1'b1;
    send_cmd(c);
    // close after a curve drops the control point; the smooth cubic reflects nothing
    send_cmd(with_args(MODE_QUAD, 1'b0, 9 * ONE, 9 * ONE, 8 * ONE, 8 * ONE, rand_q(),
                       rand_q()));
    send_cmd(with_args(MODE_CLOSE, 1'b1, rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                       rand_q()));
    send_cmd(with_args(MODE_SCUBIC, 1'b1, ONE, ONE, 2 * ONE, '0, rand_q(), rand_q()));
    send_cmd(with_args(MODE_CLOSE, 1'b0, rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                       rand_q()));
    // unused codes, the top one sets every mode bit
    send_cmd(with_args(MODE_UNUSED_LO, 1'b1, rand_q(), rand_q(), rand_q(), rand_q(),
                       rand_q(), rand_q()));
    send_cmd(with_args(MODE_UNUSED_HI, 1'b1, rand_q(), rand_q(), rand_q(), rand_q(),
                       rand_q(), rand_q()));

    run_paths(300);
    drain_results();

    // heavy output back-pressure
    gap_odds = 10;
    stall_odds = 45;
    run_paths(250);

    // tail at full rate
    gap_odds = 0;
    stall_odds = 0;
    run_paths(150);
    drain_results();
    repeat (8) @(posedge clk);

    $display("Resolved %0d of %0d commands (%0d unused codes dropped), all command kinds,",
             tracker.checked, tracker.taken, tracker.dropped);
    $display("relative and absolute, saturating adds and reflections; %0d mismatches.",
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_q.size() == 0) begin
      $display("[vector_path_command_resolver_core] OK");
    end else begin
      $display("[vector_path_command_resolver_core] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("[vector_path_command_resolver_core] ERROR");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/vpcr_pkg.sv
sv/vpcr_resolve.sv
sv/vector_path_command_resolver_core.sv
tb/tb_vector_path_command_resolver_core.sv
